/* design/rrc_pkg.sv */
// ---------------------------------------------------------------------------
// rrc_pkg: shared types and constants for the region range cache
// Entry count, request kind codes, status codes, register indexes, register
// reset values and the command bundle between controller and datapath.
// ---------------------------------------------------------------------------
package rrc_pkg;

   // Cache geometry
   localparam int ENTRIES  = 8;
   localparam int CURSOR_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

   // Request kind codes
   localparam logic [1:0] KIND_PROBE = 2'd0;
   localparam logic [1:0] KIND_FILL  = 2'd1;
   localparam logic [1:0] KIND_FLUSH = 2'd2;

   // Response status codes
   localparam logic [2:0] ST_HIT     = 3'd0;
   localparam logic [2:0] ST_MISS    = 3'd1;
   localparam logic [2:0] ST_REFUSED = 3'd2;
   localparam logic [2:0] ST_FILLED  = 3'd3;
   localparam logic [2:0] ST_FLUSHED = 3'd4;

   // Register indexes
   localparam logic [1:0] CSR_MAX_USES = 2'd0;
   localparam logic [1:0] CSR_FLOOR    = 2'd1;
   localparam logic [1:0] CSR_CEILING  = 2'd2;

   // Register reset values
   localparam logic [7:0]  MAX_USES_RST = 8'd240;
   localparam logic [31:0] FLOOR_RST    = 32'h0001_0000;
   localparam logic [31:0] CEILING_RST  = 32'h7FFF_0000;

   // Controller to datapath commands
   typedef struct packed {
      logic capture;   // latch the accepted request
      logic commit;    // apply the request and load the response register
   } dp_cmd_type;

endpackage

/* design/rrc_if.sv */
// ---------------------------------------------------------------------------
// rrc_if: channel interfaces of the region range cache
// Request, response and register write channels, each a valid/ready pair
// with its payload.
// ---------------------------------------------------------------------------

// Request channel
interface rrc_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  kind;
   logic [31:0] address;
   logic [3:0]  access_bytes;
   logic [31:0] region_base;
   logic [31:0] region_length;
   logic        region_ok;

   modport source (output valid, kind, address, access_bytes, region_base,
                   region_length, region_ok, input ready);
   modport sink   (input valid, kind, address, access_bytes, region_base,
                   region_length, region_ok, output ready);
endinterface

// Response channel
interface rrc_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  status;
   logic [31:0] hit_count;
   logic [31:0] query_count;

   modport source (output valid, status, hit_count, query_count, input ready);
   modport sink   (input valid, status, hit_count, query_count, output ready);
endinterface

// Register write channel
interface rrc_csr_if;
   logic        valid;
   logic        ready;
   logic [1:0]  index;
   logic [31:0] data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

/* design/rrc_ctrl.sv */
// ---------------------------------------------------------------------------
// rrc_ctrl: request sequencer
// Two-state machine: accept a request, then apply it once the response
// register is free. Owns the response valid flag.
// ---------------------------------------------------------------------------
module rrc_ctrl
   import rrc_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output dp_cmd_type cmd
);

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_EXEC = 2'b10
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   // Response register can take a new result this cycle
   assign out_free = !rsp_valid_ff || rsp_ready;

   // Next state and commands
   always_comb begin
      state_in    = state_ff;
      cmd.capture = 1'b0;
      cmd.commit  = 1'b0;
      req_ready   = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready   = 1'b1;
            cmd.capture = req_valid;
            if (req_valid) state_in = ST_EXEC;
         end
         ST_EXEC: begin
            if (out_free) begin
               cmd.commit = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Response valid: set on commit, cleared when taken
   assign rsp_valid_in = cmd.commit || (rsp_valid_ff && !rsp_ready);
   assign rsp_valid    = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

/* design/rrc_datapath.sv */
// ---------------------------------------------------------------------------
// rrc_datapath: entry store, range compare and counters
// Holds the registers, the captured request, the entry table and the
// response register. All entries are compared in parallel; the first
// match wins.
// ---------------------------------------------------------------------------
module rrc_datapath
   import rrc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  dp_cmd_type  cmd,
   // request payload
   input  logic [1:0]  req_kind,
   input  logic [31:0] req_address,
   input  logic [3:0]  req_access_bytes,
   input  logic [31:0] req_region_base,
   input  logic [31:0] req_region_length,
   input  logic        req_region_ok,
   // register writes
   input  logic        csr_write,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_data,
   // response payload
   output logic [2:0]  rsp_status,
   output logic [31:0] rsp_hit_count,
   output logic [31:0] rsp_query_count
);

   // Registers
   logic [7:0]  max_uses_ff;
   logic [31:0] floor_ff, ceiling_ff;

   // Captured request
   logic [1:0]  kind_ff;
   logic [31:0] addr_ff, base_ff;
   logic [32:0] stop_ff, rend_ff;
   logic        ok_ff;

   // Entry table and bookkeeping
   logic [31:0]         begin_ff [ENTRIES];
   logic [32:0]         end_ff   [ENTRIES];
   logic [7:0]          uses_ff  [ENTRIES];
   logic [CURSOR_W-1:0] cursor_ff, cursor_in;
   logic [31:0]         hits_ff, hits_in, queries_ff, queries_in;

   // Response register
   logic [2:0]  status_ff, status_in;
   logic [31:0] hit_out_ff, query_out_ff;

   // Decode
   logic               in_win, probe_live, hit, miss, fill_ok, flush, taken;
   logic [ENTRIES-1:0] match, first, expire;
   logic               ends_empty;

   // Register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         max_uses_ff <= MAX_USES_RST;
         floor_ff    <= FLOOR_RST;
         ceiling_ff  <= CEILING_RST;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_MAX_USES: max_uses_ff <= csr_data[7:0];
            CSR_FLOOR:    floor_ff    <= csr_data;
            CSR_CEILING:  ceiling_ff  <= csr_data;
            default: ;
         endcase
      end
   end

   // Request capture; end sums kept 33 bits so they never wrap
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         kind_ff <= req_kind;
         addr_ff <= req_address;
         base_ff <= req_region_base;
         stop_ff <= {1'b0, req_address} + {29'd0, req_access_bytes};
         rend_ff <= {1'b0, req_region_base} + {1'b0, req_region_length};
         ok_ff   <= req_region_ok;
      end
   end

   // Parallel range compare, first-match select, use expiry
   always_comb begin
      taken = 1'b0;
      for (int i = 0; i < ENTRIES; i++) begin
         match[i]  = (end_ff[i] != 33'd0) && (addr_ff >= begin_ff[i])
                     && (stop_ff <= end_ff[i]);
         expire[i] = ({1'b0, uses_ff[i]} + 9'd1) > {1'b0, max_uses_ff};
         first[i]  = match[i] && !taken;
         taken     = taken || match[i];
      end
   end

   assign in_win     = (addr_ff >= floor_ff) && (addr_ff < ceiling_ff);
   assign probe_live = (kind_ff == KIND_PROBE) && in_win;
   assign hit        = probe_live && ((first & ~expire) != '0);
   assign miss       = probe_live && !hit;
   assign fill_ok    = (kind_ff == KIND_FILL) && in_win && ok_ff && (stop_ff <= rend_ff);
   assign flush      = (kind_ff == KIND_FLUSH);

   // Status, counters and round-robin cursor
   always_comb begin
      case (kind_ff)
         KIND_PROBE: status_in = !in_win ? ST_REFUSED : (hit ? ST_HIT : ST_MISS);
         KIND_FILL:  status_in = fill_ok ? ST_FILLED : ST_REFUSED;
         KIND_FLUSH: status_in = ST_FLUSHED;
         default:    status_in = ST_REFUSED;
      endcase
      hits_in    = hits_ff + {31'd0, hit};
      queries_in = queries_ff + {31'd0, miss};
      cursor_in  = cursor_ff;
      if (fill_ok) begin
         if (cursor_ff == CURSOR_W'(ENTRIES - 1)) cursor_in = '0;
         else cursor_in = cursor_ff + CURSOR_W'(1);
      end
   end

   // Entry table and counters update on commit
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < ENTRIES; i++) begin
            begin_ff[i] <= '0;
            end_ff[i]   <= '0;
            uses_ff[i]  <= '0;
         end
         cursor_ff  <= '0;
         hits_ff    <= '0;
         queries_ff <= '0;
      end else if (cmd.commit) begin
         for (int i = 0; i < ENTRIES; i++) begin
            if (flush || (probe_live && first[i] && expire[i])) begin
               begin_ff[i] <= '0;
               end_ff[i]   <= '0;
               uses_ff[i]  <= '0;
            end else if (probe_live && first[i]) begin
               uses_ff[i] <= uses_ff[i] + 8'd1;
            end else if (fill_ok && (cursor_ff == CURSOR_W'(i))) begin
               begin_ff[i] <= base_ff;
               end_ff[i]   <= rend_ff;
               uses_ff[i]  <= '0;
            end
         end
         cursor_ff  <= cursor_in;
         hits_ff    <= hits_in;
         queries_ff <= queries_in;
      end
   end

   // Response register
   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         status_ff    <= status_in;
         hit_out_ff   <= hits_in;
         query_out_ff <= queries_in;
      end
   end

   assign rsp_status      = status_ff;
   assign rsp_hit_count   = hit_out_ff;
   assign rsp_query_count = query_out_ff;

   // All entries empty
   always_comb begin
      ends_empty = 1'b1;
      for (int i = 0; i < ENTRIES; i++) begin
         if (end_ff[i] != 33'd0) ends_empty = 1'b0;
      end
   end

`ifndef SYNTHESIS
   a_first_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot0(first))
      else $error("more than one entry selected");

   a_cursor_range: assert property (@(posedge clock) disable iff (reset)
      cursor_ff <= CURSOR_W'(ENTRIES - 1))
      else $error("fill cursor out of range");

   a_flush_clears: assert property (@(posedge clock) disable iff (reset)
      cmd.commit && flush |=> ends_empty)
      else $error("flush left an entry populated");

   a_counters_hold: assert property (@(posedge clock) disable iff (reset)
      !cmd.commit |=> $stable(hits_ff) && $stable(queries_ff))
      else $error("counter moved without a commit");
`endif

endmodule

/* design/region_range_cache.sv */
// ---------------------------------------------------------------------------
// region_range_cache: round-robin cache of readable address ranges
// Probes check an address against cached ranges with use-count expiry;
// fills install a region answer; flushes clear the table.
//
//   channel   dir  handshake      payload
//   req_bus   in   valid/ready    kind, address, access_bytes, region_base,
//                                 region_length, region_ok
//   rsp_bus   out  valid/ready    status, hit_count, query_count
//   csr_bus   in   valid/ready    index, data (always ready)
//
// Each request is first captured, then the parallel compare runs over all
// entries and the table is updated.
// A result sits in the response register while the next request is captured;
// the apply cycle waits only if that register is still full.
// Synchronous active-high reset clears the table, cursor, counters and
// loads the register defaults; no clearing pass is needed.
// ---------------------------------------------------------------------------
module region_range_cache
   import rrc_pkg::*;
(
   input logic         clock,
   input logic         reset,
   rrc_req_if.sink     req_bus,
   rrc_rsp_if.source   rsp_bus,
   rrc_csr_if.sink     csr_bus
);

   dp_cmd_type cmd;

   // Register port never stalls
   assign csr_bus.ready = 1'b1;

   // Sequencer
   rrc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_bus.ready),
      .rsp_valid (rsp_bus.valid),
      .rsp_ready (rsp_bus.ready),
      .cmd       (cmd)
   );

   // Table, compare and counters
   rrc_datapath u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .req_kind          (req_bus.kind),
      .req_address       (req_bus.address),
      .req_access_bytes  (req_bus.access_bytes),
      .req_region_base   (req_bus.region_base),
      .req_region_length (req_bus.region_length),
      .req_region_ok     (req_bus.region_ok),
      .csr_write         (csr_bus.valid),
      .csr_index         (csr_bus.index),
      .csr_data          (csr_bus.data),
      .rsp_status        (rsp_bus.status),
      .rsp_hit_count     (rsp_bus.hit_count),
      .rsp_query_count   (rsp_bus.query_count)
   );

endmodule

/* test/tb_region_range_cache.sv */
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_region_range_cache: self-checking bench for the region range cache
// Drives probe, fill and flush requests with random pacing on both sides.
// Register settings change between phases. A scoreboard keeps its own copy
// of the range table and predicts each response, status and both counters.
// ---------------------------------------------------------------------------
module tb_region_range_cache;
   import rrc_pkg::*;

   // Kind code the block does not define; it must answer refused
   localparam logic [1:0] KIND_UNUSED = 2'd3;
   // Cycles without any handshake before the run is declared hung
   localparam int STALL_LIMIT = 2000;

   typedef struct packed {
      logic [1:0]  kind;
      logic [31:0] address;
      logic [3:0]  access_bytes;
      logic [31:0] region_base;
      logic [31:0] region_length;
      logic        region_ok;
   } cache_req_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [31:0] hit_count;
      logic [31:0] query_count;
   } cache_rsp_type;

   typedef struct {
      logic [31:0] base;
      logic [31:0] len;
   } region_type;

   // ------------------------------------------------------------------------
   // Range table model and response checker
   // ------------------------------------------------------------------------
   class range_scoreboard;
      logic [7:0]  max_uses;
      logic [31:0] floor_addr;
      logic [31:0] ceiling_addr;
      logic [31:0] lo_addr [ENTRIES];
      logic [32:0] hi_addr [ENTRIES];
      logic [7:0]  use_count [ENTRIES];
      int          cursor;
      logic [31:0] hits;
      logic [31:0] queries;
      cache_rsp_type expected [$];
      int          errors;

      function new();
         errors = 0;
         max_uses = MAX_USES_RST;
         floor_addr = FLOOR_RST;
         ceiling_addr = CEILING_RST;
         for (int i = 0; i < ENTRIES; i++) clear_slot(i);
         cursor = 0;
         hits = '0;
         queries = '0;
      endfunction

      function void write_register(logic [1:0] index, logic [31:0] data);
         case (index)
            CSR_MAX_USES: max_uses = data[7:0];
            CSR_FLOOR:    floor_addr = data;
            CSR_CEILING:  ceiling_addr = data;
            default: ;
         endcase
      endfunction

      function void clear_slot(int i);
         lo_addr[i] = '0;
         hi_addr[i] = '0;
         use_count[i] = '0;
      endfunction

      function bit in_window(logic [31:0] addr);
         return addr >= floor_addr && addr < ceiling_addr;
      endfunction

      // First covering entry counts a use; past the limit it expires
      function logic [2:0] lookup(logic [31:0] addr, logic [32:0] stop);
         logic [8:0] next_uses;
         if (!in_window(addr)) return ST_REFUSED;
         for (int i = 0; i < ENTRIES; i++) begin
            if (hi_addr[i] != '0 && addr >= lo_addr[i] && stop <= hi_addr[i]) begin
               next_uses = {1'b0, use_count[i]} + 9'd1;
               if (next_uses > {1'b0, max_uses}) begin
                  clear_slot(i);
                  break;
               end
               use_count[i] = next_uses[7:0];
               hits = hits + 32'd1;
               return ST_HIT;
            end
         end
         queries = queries + 32'd1;
         return ST_MISS;
      endfunction

      // Region answer lands in the round-robin slot when it covers the access
      function logic [2:0] install(cache_req_type r, logic [32:0] stop);
         logic [32:0] region_end;
         if (!in_window(r.address) || !r.region_ok) return ST_REFUSED;
         region_end = {1'b0, r.region_base} + {1'b0, r.region_length};
         if (stop > region_end) return ST_REFUSED;
         lo_addr[cursor] = r.region_base;
         hi_addr[cursor] = region_end;
         use_count[cursor] = '0;
         cursor = (cursor + 1) % ENTRIES;
         return ST_FILLED;
      endfunction

      function void note_request(cache_req_type r);
         logic [32:0] stop;
         cache_rsp_type want;
         stop = {1'b0, r.address} + {29'd0, r.access_bytes};
         case (r.kind)
            KIND_PROBE: want.status = lookup(r.address, stop);
            KIND_FILL:  want.status = install(r, stop);
            KIND_FLUSH: begin
               for (int i = 0; i < ENTRIES; i++) clear_slot(i);
               want.status = ST_FLUSHED;
            end
            default:    want.status = ST_REFUSED;
         endcase
         want.hit_count = hits;
         want.query_count = queries;
         expected.push_back(want);
      endfunction

      function void mismatch(string field, logic [31:0] want, logic [31:0] got);
         errors++;
         $display("%0t: %s mismatch, expected %0d actual %0d", $time, field, want, got);
      endfunction

      function void check_response(cache_rsp_type got);
         cache_rsp_type want;
         if (expected.size() == 0) begin
            errors++;
            $display("%0t: response with nothing pending, expected none actual status %0d",
                     $time, got.status);
            return;
         end
         want = expected.pop_front();
         if (got.status !== want.status)
            mismatch("status", {29'd0, want.status}, {29'd0, got.status});
         if (got.hit_count !== want.hit_count)
            mismatch("hit_count", want.hit_count, got.hit_count);
         if (got.query_count !== want.query_count)
            mismatch("query_count", want.query_count, got.query_count);
      endfunction
   endclass

   // ------------------------------------------------------------------------
   // Clock, reset, channels and block
   // ------------------------------------------------------------------------
   logic clock;
   logic reset = 1'b1;
   int   quiet_cycles = 0;
   bit   sender_steady = 1'b0;
   region_type regions [$];
   range_scoreboard sb = new();

   rrc_req_if req_bus ();
   rrc_rsp_if rsp_bus ();
   rrc_csr_if csr_bus ();

   region_range_cache u_dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Hang detection: no handshake on any channel for too long
   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready) ||
          (csr_bus.valid && csr_bus.ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("FAILURE");
            $finish;
         end
      end
   end

   // ------------------------------------------------------------------------
   // Request generation
   // ------------------------------------------------------------------------
   // Address inside the current window, with its edges and just outside them
   function automatic logic [31:0] window_address();
      logic [31:0] lo;
      logic [31:0] hi;
      lo = sb.floor_addr;
      hi = sb.ceiling_addr;
      if (hi <= lo) return $urandom;
      case ($urandom_range(9))
         0: return lo;
         1: return hi - 32'd1;
         2: return lo - 32'd1;
         3: return hi;
         default: return $urandom_range(hi - 32'd1, lo);
      endcase
   endfunction

   // Mostly fills and probes that land in filled regions, plus noise
   function automatic cache_req_type random_request();
      cache_req_type r;
      region_type    g;
      int            roll;
      logic [31:0]   back;
      r.kind = 2'($urandom_range(3));
      r.address = $urandom;
      r.access_bytes = 4'($urandom_range(15));
      r.region_base = $urandom;
      r.region_length = $urandom;
      r.region_ok = 1'($urandom_range(1));
      roll = $urandom_range(99);
      if (roll < 40 && regions.size() > 0) begin
         g = regions[$urandom_range(regions.size() - 1)];
         r.kind = KIND_PROBE;
         r.address = g.base + $urandom_range(g.len);
         r.access_bytes = 4'(($urandom_range(9) == 0) ? $urandom_range(15)
                                                       : $urandom_range(8, 1));
      end else if (roll < 65) begin
         r.kind = KIND_FILL;
         r.address = window_address();
         r.access_bytes = 4'($urandom_range(8, 1));
         back = $urandom_range(4096);
         if (back > r.address) back = r.address;
         r.region_base = r.address - back;
         r.region_length = back + r.access_bytes + $urandom_range(4096);
         r.region_ok = 1'b1;
         case ($urandom_range(9))
            0: r.region_ok = 1'b0;
            1: r.region_length = back + r.access_bytes - 32'd1;
            2: r.region_length = $urandom;
            default: ;
         endcase
         if (r.region_ok) begin
            g.base = r.region_base;
            g.len = r.region_length;
            regions.push_back(g);
            if (regions.size() > ENTRIES) void'(regions.pop_front());
         end
      end else if (roll < 85) begin
         r.kind = KIND_PROBE;
         r.address = window_address();
         r.access_bytes = 4'($urandom_range(8, 1));
      end else if (roll < 88) begin
         r.kind = KIND_FLUSH;
      end
      return r;
   endfunction

   // ------------------------------------------------------------------------
   // Driving tasks; all inputs change at the falling edge
   // ------------------------------------------------------------------------
   task automatic send_request(cache_req_type r);
      int gap;
      gap = sender_steady ? 0 : $urandom_range(4);
      if (gap > 0) begin
         req_bus.valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_bus.kind = r.kind;
      req_bus.address = r.address;
      req_bus.access_bytes = r.access_bytes;
      req_bus.region_base = r.region_base;
      req_bus.region_length = r.region_length;
      req_bus.region_ok = r.region_ok;
      req_bus.valid = 1'b1;
      do @(posedge clock); while (!req_bus.ready);
      sb.note_request(r);
      @(negedge clock);
   endtask

   task automatic issue(logic [1:0] kind, logic [31:0] addr, logic [3:0] nbytes,
                        logic [31:0] base, logic [31:0] len, logic ok);
      cache_req_type r;
      r.kind = kind;
      r.address = addr;
      r.access_bytes = nbytes;
      r.region_base = base;
      r.region_length = len;
      r.region_ok = ok;
      send_request(r);
   endtask

   // Wait until every request has been answered
   task automatic drain();
      req_bus.valid = 1'b0;
      while (sb.expected.size() != 0) @(negedge clock);
   endtask

   task automatic csr_write(logic [1:0] index, logic [31:0] data);
      csr_bus.index = index;
      csr_bus.data = data;
      csr_bus.valid = 1'b1;
      do @(posedge clock); while (!csr_bus.ready);
      sb.write_register(index, data);
      @(negedge clock);
      csr_bus.valid = 1'b0;
   endtask

   // Register changes only while the block is idle
   task automatic configure(logic [7:0] uses, logic [31:0] lo, logic [31:0] hi);
      drain();
      csr_write(CSR_MAX_USES, {24'd0, uses});
      csr_write(CSR_FLOOR, lo);
      csr_write(CSR_CEILING, hi);
      regions.delete();
   endtask

   task automatic random_items(int count);
      for (int i = 0; i < count; i++) begin
         sender_steady = ((i / 40) % 4) == 3;
         send_request(random_request());
      end
      sender_steady = 1'b0;
   endtask

   // ------------------------------------------------------------------------
   // Response side: random stalls, check every accepted response
   // ------------------------------------------------------------------------
   initial begin
      int            stall;
      int            taken;
      cache_rsp_type got;
      taken = 0;
      rsp_bus.ready = 1'b0;
      while (reset) @(negedge clock);
      forever begin
         stall = (((taken / 32) % 4) == 2) ? 0 : $urandom_range(4);
         if (stall > 0) begin
            rsp_bus.ready = 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_bus.ready = 1'b1;
         do @(posedge clock); while (!rsp_bus.valid);
         got.status = rsp_bus.status;
         got.hit_count = rsp_bus.hit_count;
         got.query_count = rsp_bus.query_count;
         sb.check_response(got);
         taken++;
         @(negedge clock);
      end
   end

   // ------------------------------------------------------------------------
   // Stimulus
   // ------------------------------------------------------------------------
   initial begin
      req_bus.valid = 1'b0;
      req_bus.kind = KIND_PROBE;
      req_bus.address = '0;
      req_bus.access_bytes = '0;
      req_bus.region_base = '0;
      req_bus.region_length = '0;
      req_bus.region_ok = 1'b0;
      csr_bus.valid = 1'b0;
      csr_bus.index = CSR_MAX_USES;
      csr_bus.data = '0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed requests at the reset register values
      issue(KIND_PROBE, 32'h0000_0000, 4'd1, '0, '0, 1'b0);      // below floor
      issue(KIND_PROBE, 32'hFFFF_FFFF, 4'd15, '0, '0, 1'b0);     // top address
      issue(KIND_PROBE, 32'h7FFF_0000, 4'd1, '0, '0, 1'b0);      // at ceiling
      issue(KIND_PROBE, 32'h0001_0000, 4'd1, '0, '0, 1'b0);      // empty table
      issue(KIND_FILL, 32'h0001_0000, 4'd8, 32'h0001_0000, 32'h100, 1'b1);
      issue(KIND_PROBE, 32'h0001_0000, 4'd8, '0, '0, 1'b0);
      issue(KIND_PROBE, 32'h0001_00F8, 4'd8, '0, '0, 1'b0);      // ends on region end
      issue(KIND_PROBE, 32'h0001_00F9, 4'd8, '0, '0, 1'b0);      // one byte past
      issue(KIND_PROBE, 32'h0000_FFFF, 4'd1, '0, '0, 1'b0);      // floor minus one
      issue(KIND_PROBE, 32'h7FFE_FFFF, 4'd1, '0, '0, 1'b0);      // last legal address
      issue(KIND_FILL, 32'h0002_0000, 4'd8, 32'h0002_0000, 32'h100, 1'b0);  // bad region
      issue(KIND_FILL, 32'h0002_0000, 4'd8, 32'h0002_0000, 32'h4, 1'b1);    // too short
      issue(KIND_FILL, 32'h0003_0000, 4'd8, 32'h0003_0010, 32'h10, 1'b1);   // base above
      issue(KIND_PROBE, 32'h0003_0000, 4'd1, '0, '0, 1'b0);
      issue(KIND_FILL, 32'h0000_0008, 4'd1, 32'h0, 32'h100, 1'b1);          // outside window
      issue(KIND_PROBE, 32'h0001_0100, 4'd0, '0, '0, 1'b0);      // zero-byte access
      issue(KIND_UNUSED, $urandom, 4'd15, $urandom, $urandom, 1'b1);
      issue(KIND_FLUSH, $urandom, 4'd15, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
      issue(KIND_PROBE, 32'h0001_0000, 4'd1, '0, '0, 1'b0);      // gone after flush
      issue(KIND_FILL, 32'h0001_0000, 4'd15, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
      issue(KIND_PROBE, 32'h7FFE_FFF0, 4'd15, '0, '0, 1'b0);

      // Short lifetime, default window
      configure(8'd3, 32'h0001_0000, 32'h7FFF_0000);
      random_items(200);

      // Window covers all but the top address; region ending at zero leaves the slot empty
      configure(8'd1, 32'h0000_0000, 32'hFFFF_FFFF);
      issue(KIND_FILL, 32'h0, 4'd0, 32'h0, 32'h0, 1'b1);
      issue(KIND_PROBE, 32'h0, 4'd0, '0, '0, 1'b0);
      random_items(200);

      // Every match expires at once
      configure(8'd0, 32'h0000_1000, 32'h0200_0000);
      random_items(150);

      // One entry hammered past 255 uses
      configure(8'd255, 32'h0001_0000, 32'h0002_0000);
      issue(KIND_FLUSH, '0, '0, '0, '0, 1'b0);
      issue(KIND_FILL, 32'h0001_8000, 4'd8, 32'h0001_8000, 32'h1000, 1'b1);
      repeat (300) issue(KIND_PROBE, 32'h0001_8000 + $urandom_range(32'hFF8),
                         4'($urandom_range(8, 1)), $urandom, $urandom,
                         1'($urandom_range(1)));
      random_items(80);

      // Empty window: every probe and fill refused
      configure(8'd254, 32'hFFFF_FFFF, 32'h0000_0000);
      random_items(50);

      // Window at the top so region ends pass 32 bits
      configure(8'd240, 32'hFFFF_0000, 32'hFFFF_FFFF);
      random_items(240);

      drain();
      repeat (10) @(posedge clock);
      if (sb.errors == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule

/* files.f */
design/rrc_pkg.sv
design/rrc_if.sv
design/rrc_ctrl.sv
design/rrc_datapath.sv
design/region_range_cache.sv
test/tb_region_range_cache.sv
